@@ rtl/radix2_complex_fft_defines.svh @@
// Assertion macros shared by the FFT modules.
`ifndef RADIX2_COMPLEX_FFT_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_DEFINES_SVH
// Implication checked at every rising edge outside reset.
`define FFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define FFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// Types, constants and twiddle table for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;
  localparam int MaxPoints  = 64;
  localparam int SampleBits = 16;
  localparam int AccBits    = 22;
  localparam int AddrBits   = 6;
  localparam int LogBits    = 3;

  localparam logic [1:0] CfgInverse = 2'd0;
  localparam logic [1:0] CfgSize    = 2'd1;

  typedef logic signed [AccBits-1:0] acc_t;
  typedef logic [AddrBits-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_REV, ST_BFLY, ST_DRAIN, ST_EMIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic  wr_load;   // write incoming sample at addr_a
    logic  rd;        // read addr_a and addr_b
    logic  swap;      // bit-reverse swap of addr_a/addr_b data issued earlier
    logic  bfly;      // butterfly on data issued earlier
    addr_t addr_a;
    addr_t addr_b;
    logic [AddrBits-1:0] tw_idx;
    logic  emit;      // present read data as a result
    addr_t emit_idx;
    logic  emit_last;
  } cmd_t;

  // Quarter-wave cosine table, Q1.15, entry 0 is exactly one.
  function automatic logic [16:0] qw(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0: v = 17'd32768;  5'd1: v = 17'd32610;  5'd2: v = 17'd32138;
      5'd3: v = 17'd31357;  5'd4: v = 17'd30274;  5'd5: v = 17'd28899;
      5'd6: v = 17'd27246;  5'd7: v = 17'd25330;  5'd8: v = 17'd23170;
      5'd9: v = 17'd20788;  5'd10: v = 17'd18205; 5'd11: v = 17'd15447;
      5'd12: v = 17'd12540; 5'd13: v = 17'd9512;  5'd14: v = 17'd6393;
      5'd15: v = 17'd3212;  default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Twiddle index k is in 0..31 for all butterflies.
  function automatic logic signed [17:0] tw_cos(input logic [AddrBits-1:0] k);
    logic signed [17:0] r;
    if (k <= 6'd16) r = signed'({1'b0, qw(k[4:0])});
    else r = -signed'({1'b0, qw(5'(6'd32 - k))});
    return r;
  endfunction

  function automatic logic signed [17:0] tw_sin(input logic [AddrBits-1:0] k);
    logic signed [17:0] r;
    if (k <= 6'd16) r = signed'({1'b0, qw(5'(6'd16 - k))});
    else r = signed'({1'b0, qw(5'(k - 6'd16))});
    return r;
  endfunction

  function automatic acc_t sat_acc(input logic signed [AccBits+1:0] v);
    acc_t r;
    if (v > 24'sd2097151) r = acc_t'(22'sh1FFFFF);
    else if (v < -24'sd2097152) r = acc_t'(22'sh200000);
    else r = acc_t'(v);
    return r;
  endfunction
endpackage

@@ rtl/r2fft_ctrl.sv @@
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer for load, bit reversal, butterfly stages and bin output.
// ----------------------------------------------------------------------------
`include "radix2_complex_fft_defines.svh"
module r2fft_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_fire,
  input  logic [r2fft_pkg::LogBits-1:0] lg,
  input  logic                          out_busy,
  output logic                          in_ready,
  output r2fft_pkg::cmd_t               cmd
);
  import r2fft_pkg::*;

  state_t state, state_next;
  logic [6:0] cnt, cnt_next;       // load count / generic counter
  logic [2:0] stage, stage_next;   // butterfly stage, 0..lg-1
  logic [2:0] lg_r, lg_r_next;
  logic [2:0] drain, drain_next;
  logic [6:0] n_pts;
  logic [5:0] rev;
  logic [5:0] half, k, base, ia, ib;

  assign n_pts = 7'd1 << lg_r;

  always_comb begin
    rev = '0;
    for (int b = 0; b < AddrBits; b++)
      if (b < lg_r) rev[lg_r - 3'd1 - 3'(b)] = cnt[b];
  end

  // Butterfly j = cnt over n/2: half = 2^stage, k = j mod half.
  always_comb begin
    half = 6'd1 << stage;
    k    = cnt[5:0] & (half - 6'd1);
    base = (cnt[5:0] & ~(half - 6'd1)) << 1;
    ia   = base | k;
    ib   = ia | half;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; cnt <= '0; stage <= '0; lg_r <= 3'd6; drain <= '0;
    end else begin
      state <= state_next; cnt <= cnt_next; stage <= stage_next;
      lg_r <= lg_r_next; drain <= drain_next;
    end
  end

  always_comb begin
    state_next = state; cnt_next = cnt; stage_next = stage;
    lg_r_next = lg_r; drain_next = drain;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = !rst;
        lg_r_next = lg;
        if (in_fire) begin
          cmd.wr_load = 1'b1;
          cmd.addr_a = cnt[5:0];
          // With the size lowered below what is already loaded, this transfer
          // completes the frame; its sample lands past the frame end unread.
          if (cnt + 7'd1 >= (7'd1 << lg)) begin
            state_next = ST_REV; cnt_next = '0;
          end else cnt_next = cnt + 7'd1;
        end
      end
      ST_REV: begin
        // One index a cycle; a swap stalls it for its read, then its write.
        if (drain != 3'd0) begin
          drain_next = drain - 3'd1;
        end else begin
          if ({1'b0, cnt[5:0]} < {1'b0, rev} && cnt < n_pts) begin
            cmd.rd = 1'b1; cmd.swap = 1'b1;
            cmd.addr_a = cnt[5:0]; cmd.addr_b = rev;
            drain_next = 3'd2;
          end
          if (cnt + 7'd1 >= n_pts) begin
            state_next = ST_BFLY; cnt_next = '0; stage_next = '0;
            drain_next = 3'd3;
          end else cnt_next = cnt + 7'd1;
        end
      end
      ST_BFLY: begin
        // Wait for the previous stage to be written back before reading.
        if (drain != 3'd0) begin
          drain_next = drain - 3'd1;
        end else begin
          cmd.rd = 1'b1; cmd.bfly = 1'b1;
          cmd.addr_a = ia; cmd.addr_b = ib;
          cmd.tw_idx = 6'(k << (3'd5 - stage));
          if (cnt + 7'd1 >= (n_pts >> 1)) begin
            cnt_next = '0;
            drain_next = 3'd5;
            if (stage + 3'd1 >= lg_r) state_next = ST_DRAIN;
            else stage_next = stage + 3'd1;
          end else cnt_next = cnt + 7'd1;
        end
      end
      ST_DRAIN: begin
        if (drain != 3'd0) drain_next = drain - 3'd1;
        else begin state_next = ST_EMIT; cnt_next = '0; end
      end
      ST_EMIT: begin
        if (drain != 3'd0) drain_next = drain - 3'd1;
        else if (!out_busy) begin
          cmd.rd = 1'b1; cmd.emit = 1'b1;
          cmd.addr_a = cnt[5:0]; cmd.emit_idx = cnt[5:0];
          cmd.emit_last = (cnt + 7'd1 == n_pts);
          // The bin is read, then registered, before the next bin is read.
          drain_next = 3'd1;
          if (cnt + 7'd1 >= n_pts) begin
            state_next = ST_LOAD; cnt_next = '0; drain_next = 3'd0;
          end else cnt_next = cnt + 7'd1;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  `FFT_ASSERT_IMP(a_ready_load, in_ready, state == ST_LOAD, "ready outside load")
  `FFT_ASSERT_IMP(a_cnt_range, state == ST_BFLY, cnt < 7'd32, "butterfly count range")
  `FFT_ASSERT_NEXT(a_emit_done, cmd.emit && cmd.emit_last, state == ST_LOAD, "no load after bin")
endmodule

@@ rtl/r2fft_dp.sv @@
// ----------------------------------------------------------------------------
// r2fft_dp
// Frame memory, pipelined butterfly unit and output register.
// ----------------------------------------------------------------------------
`include "radix2_complex_fft_defines.svh"
module r2fft_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  r2fft_pkg::cmd_t                  cmd,
  input  logic [r2fft_pkg::SampleBits-1:0] sample_re,
  input  logic [r2fft_pkg::SampleBits-1:0] sample_im,
  input  logic                             inv,
  input  logic [r2fft_pkg::LogBits-1:0]    lg,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_busy,
  output logic [55:0]                      out_data
);
  import r2fft_pkg::*;

  logic [2*AccBits-1:0] mem [MaxPoints];
  logic [2*AccBits-1:0] rd_a, rd_b;

  // Pipeline stage 1: read data; stage 2: products; stage 3: write back.
  logic  p1_swap, p1_bfly, p1_emit, p1_last;
  addr_t p1_a, p1_b, p1_idx;
  logic signed [17:0] p1_c, p1_s;
  logic  p2_bfly;
  addr_t p2_a, p2_b;
  acc_t  p2_ar, p2_ai;
  logic signed [40:0] p2_rr, p2_ri, p2_ir, p2_ii;
  acc_t  wr_re, wr_im, wb_re, wb_im;
  logic signed [42:0] tr_full, ti_full;
  logic signed [27:0] tr, ti;
  logic signed [AccBits-1:0] br, bi;
  acc_t  o_re, o_im;

  assign br = rd_b[2*AccBits-1:AccBits];
  assign bi = rd_b[AccBits-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_load)
      mem[cmd.addr_a] <= {acc_t'(signed'(sample_re)), acc_t'(signed'(sample_im))};
    else if (p1_swap) begin
      mem[p1_a] <= rd_b;
    end else if (p2_bfly)
      mem[p2_a] <= {wr_re, wr_im};
    if (p1_swap) mem[p1_b] <= rd_a;
    else if (p2_bfly) mem[p2_b] <= {wb_re, wb_im};
    if (cmd.rd) begin
      rd_a <= mem[cmd.addr_a];
      rd_b <= mem[cmd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_swap <= 1'b0; p1_bfly <= 1'b0; p1_emit <= 1'b0; p2_bfly <= 1'b0;
    end else begin
      p1_swap <= cmd.swap; p1_bfly <= cmd.bfly; p1_emit <= cmd.emit;
      p2_bfly <= p1_bfly;
    end
    p1_a <= cmd.addr_a; p1_b <= cmd.addr_b; p1_idx <= cmd.emit_idx;
    p1_last <= cmd.emit_last;
    p1_c <= tw_cos(cmd.tw_idx);
    p1_s <= inv ? tw_sin(cmd.tw_idx) : -tw_sin(cmd.tw_idx);
    p2_a <= p1_a; p2_b <= p1_b;
    p2_ar <= rd_a[2*AccBits-1:AccBits]; p2_ai <= rd_a[AccBits-1:0];
    p2_rr <= 41'(br * p1_c); p2_ii <= 41'(bi * p1_s);
    p2_ri <= 41'(br * p1_s); p2_ir <= 41'(bi * p1_c);
  end

  always_comb begin
    tr_full = (43'(p2_rr) - 43'(p2_ii) + 43'sd16384) >>> 15;
    ti_full = (43'(p2_ri) + 43'(p2_ir) + 43'sd16384) >>> 15;
    tr = 28'(tr_full); ti = 28'(ti_full);
    wr_re = sat_acc(24'(28'(p2_ar) + tr));
    wr_im = sat_acc(24'(28'(p2_ai) + ti));
    wb_re = sat_acc(24'(28'(p2_ar) - tr));
    wb_im = sat_acc(24'(28'(p2_ai) - ti));
    if (inv) begin
      o_re = acc_t'(signed'(rd_a[2*AccBits-1:AccBits]) >>> lg);
      o_im = acc_t'(signed'(rd_a[AccBits-1:0]) >>> lg);
    end else begin
      o_re = rd_a[2*AccBits-1:AccBits];
      o_im = rd_a[AccBits-1:0];
    end
  end

  // Output register: holds one bin until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (p1_emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (p1_emit) out_data <= {5'd0, p1_last, p1_idx, o_im, o_re};
  end

  assign out_busy = out_valid && !out_ready;

  `FFT_ASSERT_IMP(a_no_overrun, p1_emit, !out_valid || out_ready, "bin overwritten")
  `FFT_ASSERT_IMP(a_no_clash, cmd.wr_load, !p1_swap && !p2_bfly, "write port clash")
  `FFT_ASSERT_IMP(a_exclusive, p1_bfly, !p1_swap && !p1_emit, "mixed pipeline ops")
endmodule

@@ rtl/radix2_complex_fft.sv @@
// After the last sample transfer the frame is bit-reversed, then each butterfly stage
// is run and written back, then the pipeline drains and the bins are emitted.
// Bins wait when the sink stalls; a new frame is loaded only after the last bin.
// The frame memory serves one butterfly a cycle within a stage; each bin needs a read
// and a pass through the output register.
// Reset: synchronous, active high; forward mode, size 64, nothing loaded, memory kept.
// ----------------------------------------------------------------------------
// radix2_complex_fft
// Radix-2 decimation-in-time complex FFT with streaming ports.
// ----------------------------------------------------------------------------
module radix2_complex_fft (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_re [15:0], sample_im [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // bin_re [21:0], bin_im [43:22], bin_index [49:44]
  output logic        m_axis_tlast,   // last_bin
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import r2fft_pkg::*;

  logic       inverse_mode;
  logic [2:0] size_log2, lg;
  logic       in_fire, out_busy;
  logic [55:0] raw;
  cmd_t       cmd;

  assign cfg_ready = !rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0; size_log2 <= 3'd6;
    end else if (cfg_valid) begin
      if ({1'b0, cfg_index} == CfgInverse) inverse_mode <= cfg_data[0];
      else size_log2 <= cfg_data;
    end
  end

  assign lg = (size_log2 == 3'd0) ? 3'd1 : (size_log2 > 3'd6) ? 3'd6 : size_log2;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  r2fft_ctrl u_ctrl (
    .clk, .rst, .in_fire, .lg, .out_busy, .in_ready(s_axis_tready), .cmd
  );

  r2fft_dp u_dp (
    .clk, .rst, .cmd,
    .sample_re(s_axis_tdata[15:0]), .sample_im(s_axis_tdata[31:16]),
    .inv(inverse_mode), .lg, .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid), .out_busy, .out_data(raw)
  );

  assign m_axis_tdata = {6'd0, raw[49:0]};
  assign m_axis_tlast = raw[50];
endmodule
